/* hw/rtl/huffman_code_builder_defines.svh */
// ---------------------------------------------------------------------------
// Huffman code builder assertion macros
// Shared concurrent assertion helpers.
// ---------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BUILDER_DEFINES_SVH
`define HUFFMAN_CODE_BUILDER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define HCB_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define HCB_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

/* hw/rtl/hcb_pkg.sv */
// ---------------------------------------------------------------------------
// hcb_pkg
// Types and constants of the Huffman code builder.
// ---------------------------------------------------------------------------
package hcb_pkg;

    localparam int MAX_SYMBOLS = 64;
    localparam int FREQ_BITS   = 24;
    localparam int NODE_COUNT  = 2 * MAX_SYMBOLS;
    localparam int IDX_W       = $clog2(MAX_SYMBOLS);
    localparam int CNT_W       = $clog2(MAX_SYMBOLS + 1);
    localparam int NODE_W      = $clog2(NODE_COUNT);
    localparam int WGT_W       = FREQ_BITS + IDX_W;
    localparam int LEN_W       = 6;
    localparam int CODE_W      = 63;

    typedef struct packed {
        logic [7:0]  symbol;
        logic [23:0] frequency;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic [7:0]        out_symbol;
        logic [LEN_W-1:0]  code_length;
        logic [CODE_W-1:0] code_bits;
        logic              out_last;
    } t_out_item;

endpackage

/* hw/rtl/hcb_stream_if.sv */
// ---------------------------------------------------------------------------
// hcb_stream_if
// Valid/ready channel carrying one request payload.
// ---------------------------------------------------------------------------
interface hcb_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/huffman_code_builder.sv */
// ---------------------------------------------------------------------------
// huffman_code_builder
// Builds Huffman codes from loaded (symbol, frequency) requests.
// ---------------------------------------------------------------------------
// Usage:
//   i_in carries (symbol, frequency, last) requests; o_out returns one
//   (out_symbol, code_length, code_bits, out_last) request per loaded symbol,
//   in load order, after a request with last set.
//   Loading accepts one request per cycle while i_in is ready. After last,
//   the heap is built and merged in a weight/node memory with two read ports
//   and one write port: each sift step is a read state then a compare/write
//   state. Each merge is two pops, each with a sift-down of the moved tail
//   entry, then a merge step that writes the parent memory, then a sift-up.
//   Code readout walks the parent memory, one edge a cycle, from each
//   symbol's leaf up to the root.
//   i_in is not ready from the last request until the last code is taken.
//   Requests beyond MAX_SYMBOLS are dropped (last still starts a build).
//   A stalled receiver holds the output register; the emit step waits for it.
//   Reset clears counters and state; memories need no clearing.
// ---------------------------------------------------------------------------
`include "huffman_code_builder_defines.svh"

module huffman_code_builder
    import hcb_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    hcb_stream_if.sink   i_in,
    hcb_stream_if.source o_out
);

    typedef enum logic [10:0] {
        S_LOAD  = 11'b00000000001,
        S_HEAPI = 11'b00000000010,
        S_SDRD  = 11'b00000000100,
        S_SDCMP = 11'b00000001000,
        S_POP   = 11'b00000010000,
        S_POPW  = 11'b00000100000,
        S_MERGE = 11'b00001000000,
        S_SURD  = 11'b00010000000,
        S_SUCMP = 11'b00100000000,
        S_WALK  = 11'b01000000000,
        S_EMIT  = 11'b10000000000
    } t_state;

    // heap memories (weight and node packed together)
    localparam int HE_W = WGT_W + NODE_W;
    logic [HE_W-1:0]   heap_mem [MAX_SYMBOLS];
    logic [7:0]        sym_mem [MAX_SYMBOLS];
    logic [NODE_W:0]   par_mem [NODE_COUNT];

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_hsize, n_hsize;
    logic [NODE_W-1:0] r_nint, n_nint;
    logic [CNT_W-1:0]  r_k, n_k;          // build-heap index
    logic [IDX_W-1:0]  r_id, n_id;        // sift position
    logic              r_bld, n_bld;      // sifting for build phase
    logic              r_second, n_second;
    logic [HE_W-1:0]   r_x, n_x;          // first popped
    logic [HE_W-1:0]   r_y, n_y;          // second popped
    logic [HE_W-1:0]   r_cur, n_cur;      // entry being sifted
    logic [CNT_W-1:0]  r_sym, n_sym;      // emit index
    logic [NODE_W-1:0] r_node, n_node;
    logic [NODE_W-1:0] r_root, n_root;
    logic [LEN_W:0]    r_depth, n_depth;
    logic [CODE_W-1:0] r_code, n_code;
    logic              r_ovalid, n_ovalid;
    t_out_item         r_oitem, n_oitem;

    // memory ports
    logic [IDX_W-1:0]  ra_a, ra_b;
    logic [HE_W-1:0]   rd_a, rd_b;
    logic              wa_en;
    logic [IDX_W-1:0]  wa_ad;
    logic [HE_W-1:0]   wa_d;
    logic              pw_en;
    logic [NODE_W-1:0] pw_ad0, pw_ad1;
    logic [NODE_W-1:0] pw_val;
    logic [NODE_W-1:0] pr_ad;
    logic [NODE_W:0]   pr_d;
    logic [7:0]        sr_d;

    always_ff @(posedge i_clk) begin
        rd_a <= heap_mem[ra_a];
        rd_b <= heap_mem[ra_b];
        if (wa_en) begin
            heap_mem[wa_ad] <= wa_d;
        end
    end

    always_ff @(posedge i_clk) begin
        pr_d <= par_mem[pr_ad];
        if (pw_en) begin
            par_mem[pw_ad0] <= {1'b0, pw_val};
            par_mem[pw_ad1] <= {1'b1, pw_val};
        end
    end

    logic in_fire;
    assign in_fire = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        sr_d <= sym_mem[r_sym[IDX_W-1:0]];
        if (in_fire && r_count < CNT_W'(MAX_SYMBOLS)) begin
            sym_mem[r_count[IDX_W-1:0]] <= i_in.data.symbol;
        end
    end

    function automatic logic [WGT_W-1:0] f_w(input logic [HE_W-1:0] e);
        return e[HE_W-1:NODE_W];
    endfunction

    logic [CNT_W:0]    c_l, c_r;
    logic              c_hasl, c_hasr, c_pickr, c_swap;
    logic [HE_W-1:0]   c_pick;
    logic [IDX_W-1:0]  c_up;
    logic [WGT_W-1:0]  c_sum;
    logic [NODE_W-1:0] c_z;

    assign i_in.ready  = (r_state == S_LOAD) && !r_ovalid;
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_oitem;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_hsize  = r_hsize;
        n_nint   = r_nint;
        n_k      = r_k;
        n_id     = r_id;
        n_bld    = r_bld;
        n_second = r_second;
        n_x      = r_x;
        n_y      = r_y;
        n_cur    = r_cur;
        n_sym    = r_sym;
        n_node   = r_node;
        n_root   = r_root;
        n_depth  = r_depth;
        n_code   = r_code;
        n_ovalid = r_ovalid;
        n_oitem  = r_oitem;
        ra_a     = '0;
        ra_b     = '0;
        wa_en    = 1'b0;
        wa_ad    = '0;
        wa_d     = '0;
        pw_en    = 1'b0;
        pw_ad0   = r_x[NODE_W-1:0];
        pw_ad1   = r_y[NODE_W-1:0];
        pw_val   = '0;
        pr_ad    = r_node;
        c_l      = {1'b0, r_id, 1'b1};
        c_r      = c_l + 1'b1;
        c_hasl   = c_l < (CNT_W+1)'(r_hsize);
        c_hasr   = c_r < (CNT_W+1)'(r_hsize);
        c_pickr  = c_hasr && (f_w(rd_b) < f_w(rd_a));
        c_pick   = c_pickr ? rd_b : rd_a;
        c_swap   = c_hasl && (f_w(r_cur) > f_w(c_pick));
        c_up     = (r_id - 1'b1) >> 1;
        c_sum    = f_w(r_x) + f_w(r_y);
        c_z      = NODE_W'(r_count) + r_nint;

        if (o_out.valid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_LOAD: begin
                if (in_fire) begin
                    if (r_count < CNT_W'(MAX_SYMBOLS)) begin
                        wa_en   = 1'b1;
                        wa_ad   = r_count[IDX_W-1:0];
                        wa_d    = {WGT_W'(i_in.data.frequency[FREQ_BITS-1:0]),
                                   NODE_W'(r_count)};
                        n_count = r_count + 1'b1;
                    end
                    if (i_in.data.last) begin
                        n_hsize = n_count;
                        n_nint  = '0;
                        n_k     = (n_count >> 1) + 1'b1;
                        n_state = S_HEAPI;
                    end
                end
            end
            S_HEAPI: begin
                if (r_k == '0) begin
                    n_state = S_POP;
                end else begin
                    n_id    = IDX_W'(r_k - 1'b1);
                    n_k     = r_k - 1'b1;
                    n_bld   = 1'b1;
                    ra_a    = IDX_W'(r_k - 1'b1);
                    n_state = S_SDRD;
                end
            end
            S_SDRD: begin
                // rd_a holds cur when entering from build; load it
                if (r_bld && r_k == CNT_W'(r_id)) begin
                    n_cur = rd_a;
                    n_bld = 1'b0;
                end
                ra_a    = c_l[IDX_W-1:0];
                ra_b    = c_r[IDX_W-1:0];
                n_state = S_SDCMP;
                if (r_bld && r_k == CNT_W'(r_id)) begin
                    n_bld = 1'b1;
                end
            end
            S_SDCMP: begin
                if (c_swap) begin
                    wa_en   = 1'b1;
                    wa_ad   = r_id;
                    wa_d    = c_pick;
                    n_id    = c_pickr ? c_r[IDX_W-1:0] : c_l[IDX_W-1:0];
                    n_state = S_SDRD;
                end else begin
                    wa_en   = 1'b1;
                    wa_ad   = r_id;
                    wa_d    = r_cur;
                    n_state = r_bld ? S_HEAPI : S_POP;
                end
                if (c_swap) begin
                    ra_a = c_pickr ? c_r[IDX_W-1:0] : c_l[IDX_W-1:0];
                end
            end
            S_POP: begin
                if (!r_second && r_hsize <= CNT_W'(1)) begin
                    n_root  = (r_count > CNT_W'(1)) ? (c_z - 1'b1) : '0;
                    n_sym   = '0;
                    n_state = S_WALK;
                    n_node  = '0;
                    n_depth = '0;
                    n_code  = '0;
                    pr_ad   = '0;
                    n_bld   = 1'b0;
                    n_k     = '0;
                end else begin
                    ra_a    = '0;
                    ra_b    = IDX_W'(r_hsize - 1'b1);
                    n_bld   = 1'b0;
                    n_state = S_POPW;
                end
            end
            S_POPW: begin
                if (!r_second) begin
                    n_x = rd_a;
                end else begin
                    n_y = rd_a;
                end
                // sift the moved tail entry down
                n_hsize  = r_hsize - 1'b1;
                n_cur    = rd_b;
                n_id     = '0;
                n_second = !r_second;
                n_k      = '0;
                n_state  = S_SDRD;
            end
            S_MERGE: begin
                pw_en   = 1'b1;
                pw_ad0  = r_x[NODE_W-1:0];
                pw_ad1  = r_y[NODE_W-1:0];
                pw_val  = c_z;
                n_cur   = {c_sum, c_z};
                n_id    = IDX_W'(r_hsize);
                n_hsize = r_hsize + 1'b1;
                n_nint  = r_nint + 1'b1;
                ra_a    = IDX_W'((r_hsize - 1'b1) >> 1);
                n_state = S_SURD;
            end
            S_SURD: begin
                ra_a    = c_up;
                n_state = S_SUCMP;
            end
            S_SUCMP: begin
                if (r_id != '0 && f_w(rd_a) > f_w(r_cur)) begin
                    wa_en   = 1'b1;
                    wa_ad   = r_id;
                    wa_d    = rd_a;
                    n_id    = c_up;
                    n_state = S_SURD;
                end else begin
                    wa_en   = 1'b1;
                    wa_ad   = r_id;
                    wa_d    = r_cur;
                    n_state = S_POP;
                end
            end
            S_WALK: begin
                // r_bld: 0 = address issued, 1 = data valid
                if (!r_bld) begin
                    pr_ad = r_node;
                    n_bld = 1'b1;
                end else if (r_node == r_root) begin
                    n_state = S_EMIT;
                    n_bld   = 1'b0;
                end else begin
                    if (pr_d[NODE_W] && r_depth < (LEN_W+1)'(CODE_W)) begin
                        n_code = r_code | (CODE_W'(1) << r_depth);
                    end
                    n_depth = r_depth + 1'b1;
                    n_node  = pr_d[NODE_W-1:0];
                    pr_ad   = pr_d[NODE_W-1:0];
                end
            end
            S_EMIT: begin
                if (!n_ovalid) begin
                    n_ovalid               = 1'b1;
                    n_oitem.out_symbol     = sr_d;
                    n_oitem.code_length    = (r_depth > (LEN_W+1)'(CODE_W)) ?
                                             LEN_W'(CODE_W) : r_depth[LEN_W-1:0];
                    n_oitem.code_bits      = r_code;
                    n_oitem.out_last       = (r_sym + 1'b1 == r_count);
                    if (r_sym + 1'b1 == r_count) begin
                        n_count = '0;
                        n_hsize = '0;
                        n_nint  = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_sym   = r_sym + 1'b1;
                        n_node  = NODE_W'(r_sym + 1'b1);
                        n_depth = '0;
                        n_code  = '0;
                        n_state = S_WALK;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase

        // after the second pop's sift completes, merge
        if (r_state == S_SDCMP && !c_swap && !r_bld && !r_second) begin
            n_state = S_MERGE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= '0;
            r_hsize  <= '0;
            r_nint   <= '0;
            r_k      <= '0;
            r_bld    <= 1'b0;
            r_second <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_hsize  <= n_hsize;
            r_nint   <= n_nint;
            r_k      <= n_k;
            r_bld    <= n_bld;
            r_second <= n_second;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id    <= n_id;
        r_x     <= n_x;
        r_y     <= n_y;
        r_cur   <= n_cur;
        r_sym   <= n_sym;
        r_node  <= n_node;
        r_root  <= n_root;
        r_depth <= n_depth;
        r_code  <= n_code;
        r_oitem <= n_oitem;
    end

    `HCB_ASSERT_IMP(a_ready_load, i_clk, i_rst_n, i_in.ready, r_state == S_LOAD)
    `HCB_ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_SYMBOLS))
    `HCB_ASSERT_IMP(a_hsize_le, i_clk, i_rst_n, r_state != S_LOAD, r_hsize <= r_count)
    `HCB_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_out.valid && !o_out.ready, o_out.valid)

endmodule
